// ===== rtl/core/dhcc_pkg.sv =====
// shared constants and types for the dual hall center calibration block
package dhcc_pkg;
  localparam int ANGLE_BITS_DEF = 24;
  localparam int SETTLE_TICKS = 40;
  localparam int SETTLE_W = 6;
  localparam int TICKS_W = 17;
  localparam int ADDR_W = 5;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CAL = 2'd1;
  localparam logic [1:0] ST_OK = 2'd2;
  localparam logic [1:0] ST_FAIL = 2'd3;

  localparam logic [2:0] PH_PROBE = 3'd0;
  localparam logic [2:0] PH_BACK = 3'd1;
  localparam logic [2:0] PH_EDGE = 3'd2;
  localparam logic [2:0] PH_REV = 3'd3;
  localparam logic [2:0] PH_CENTER = 3'd4;

  localparam logic [1:0] MODE_SINGLE = 2'd0;
  localparam logic [1:0] MODE_NORMAL = 2'd1;
  localparam logic [1:0] MODE_MIRROR = 2'd2;
  localparam logic [1:0] MODE_RSVD = 2'd3;

  localparam logic [ADDR_W-1:0] REG_MODE = 5'd0;
  localparam logic [ADDR_W-1:0] REG_STEP = 5'd4;
  localparam logic [ADDR_W-1:0] REG_LMIN = 5'd8;
  localparam logic [ADDR_W-1:0] REG_LMAX = 5'd12;
  localparam logic [ADDR_W-1:0] REG_PROBE = 5'd16;
  localparam logic [ADDR_W-1:0] REG_OVER = 5'd20;
  localparam logic [ADDR_W-1:0] REG_TOL = 5'd24;
  localparam logic [ADDR_W-1:0] REG_TIMEOUT = 5'd28;

  typedef struct packed {
    logic [1:0] mount_mode;
    logic [15:0] step_size;
    logic [23:0] limit_min;
    logic [23:0] limit_max;
    logic [22:0] probe_travel;
    logic [22:0] overtravel;
    logic [22:0] final_tolerance;
    logic [15:0] timeout_ticks;
  } cfg_t;
endpackage

// ===== rtl/core/dual_hall_center_calibration.sv =====
// top level of the dual hall center calibration sequencer
// usage:
//   s_axis carries one word per control tick: action (0 start, 1 tick),
//   measured angle and the two active-low hall levels.
//   m_axis returns one word per input word: position command, status,
//   phase, zero strobe and the sweep transition count.
//   the apb port writes and reads the eight setup registers at 4*i; write
//   them only while no word is in flight.
// datapath and throughput:
//   a word is taken into the state registers on acceptance, and those
//   registers drive m_tdata directly; one word per cycle is sustained
//   while m_tready stays high.
// reset:
//   rst (synchronous) clears the sequencer to idle, loads register defaults
//   and drops m_tvalid.
// stall:
//   while m_tvalid is high and m_tready is low the result holds and
//   s_tready drops; with m_tready high a new word may be taken in the
//   same cycle that the held result is taken.
module dual_hall_center_calibration (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // position[23:0], sensor_a_level[24], sensor_b_level[25]
  input  logic        s_tuser,  // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,  // position_command, cal_status, cal_phase, zero_strobe,
                                // edge_transitions from bit 0 up
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [dhcc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  dhcc_pkg::cfg_t cfg;
  logic en;
  logic [23:0] res_command;
  logic [1:0] res_status;
  logic [2:0] res_phase;
  logic res_strobe;
  logic [15:0] res_trans;

  assign pready = 1'b1;
  assign s_tready = !m_tvalid || m_tready;
  assign en = s_tvalid && s_tready;

  dhcc_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .cfg
  );

  dhcc_seq u_seq (
    .clk, .rst, .en, .cfg,
    .action(s_tuser),
    .position(s_tdata[23:0]),
    .sa(s_tdata[24]),
    .sb(s_tdata[25]),
    .res_command, .res_status, .res_phase, .res_strobe, .res_trans
  );

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  assign m_tdata = {2'd0, res_trans, res_strobe, res_phase, res_status, res_command};

  a_strobe_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[29] |-> m_tdata[25:24] == dhcc_pkg::ST_OK)
    else $error("strobe without success");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");
  a_phase: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[28:26] <= dhcc_pkg::PH_CENTER)
    else $error("bad phase");
endmodule

// ===== rtl/core/dhcc_regs.sv =====
// apb configuration register file
module dhcc_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dhcc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output dhcc_pkg::cfg_t             cfg
);
  logic wr;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mount_mode <= 2'd1;
      cfg.step_size <= 16'd67;
      cfg.limit_min <= 24'hE00000;
      cfg.limit_max <= 24'h200000;
      cfg.probe_travel <= 23'd1398101;
      cfg.overtravel <= 23'd699051;
      cfg.final_tolerance <= 23'd46603;
      cfg.timeout_ticks <= 16'd40000;
    end else if (wr) begin
      case (paddr)
        dhcc_pkg::REG_MODE: cfg.mount_mode <= pwdata[1:0];
        dhcc_pkg::REG_STEP: cfg.step_size <= pwdata[15:0];
        dhcc_pkg::REG_LMIN: cfg.limit_min <= pwdata[23:0];
        dhcc_pkg::REG_LMAX: cfg.limit_max <= pwdata[23:0];
        dhcc_pkg::REG_PROBE: cfg.probe_travel <= pwdata[22:0];
        dhcc_pkg::REG_OVER: cfg.overtravel <= pwdata[22:0];
        dhcc_pkg::REG_TOL: cfg.final_tolerance <= pwdata[22:0];
        dhcc_pkg::REG_TIMEOUT: cfg.timeout_ticks <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      dhcc_pkg::REG_MODE: prdata = {30'd0, cfg.mount_mode};
      dhcc_pkg::REG_STEP: prdata = {16'd0, cfg.step_size};
      dhcc_pkg::REG_LMIN: prdata = {8'd0, cfg.limit_min};
      dhcc_pkg::REG_LMAX: prdata = {8'd0, cfg.limit_max};
      dhcc_pkg::REG_PROBE: prdata = {9'd0, cfg.probe_travel};
      dhcc_pkg::REG_OVER: prdata = {9'd0, cfg.overtravel};
      dhcc_pkg::REG_TOL: prdata = {9'd0, cfg.final_tolerance};
      dhcc_pkg::REG_TIMEOUT: prdata = {16'd0, cfg.timeout_ticks};
      default: prdata = 32'd0;
    endcase
  end
endmodule

// ===== rtl/core/dhcc_seq.sv =====
// homing sequencer state and next-state logic, one word per cycle while en is high
module dhcc_seq (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  dhcc_pkg::cfg_t                      cfg,
  input  logic                                action,
  input  logic [dhcc_pkg::ANGLE_BITS_DEF-1:0] position,
  input  logic                                sa,
  input  logic                                sb,
  output logic [23:0]                         res_command,
  output logic [1:0]                          res_status,
  output logic [2:0]                          res_phase,
  output logic                                res_strobe,
  output logic [15:0]                         res_trans
);
  localparam int W = dhcc_pkg::ANGLE_BITS_DEF;
  localparam int WE = W + 2;
  localparam int SW = dhcc_pkg::SETTLE_W;

  logic [1:0] status_reg;
  logic [2:0] phase_reg;
  logic moving_down, prev_both_active, reverse_armed;
  logic [W-1:0] command_reg, phase_start_angle, forward_edge_angle, center_target;
  logic [dhcc_pkg::SETTLE_W-1:0] settle_count;
  logic [dhcc_pkg::TICKS_W-1:0] approach_ticks;
  logic [1:0] prev_levels;
  logic [15:0] transition_count;

  logic [1:0] status_next;
  logic [2:0] phase_next;
  logic md_next, pba_next, ra_next, strobe;
  logic [W-1:0] cmd_next, psa_next, fea_next, ct_next;
  logic [dhcc_pkg::SETTLE_W-1:0] sc_next;
  logic [dhcc_pkg::TICKS_W-1:0] at_next;
  logic [1:0] pl_next;
  logic [15:0] tc_next;

  logic a_act, b_act, both, up_down, bot_act, top_act;
  logic [1:0] levels;
  logic signed [WE-1:0] lo, hi, cmd_s, stp, j_up, j_dn, jsel, clamped;
  logic signed [WE-1:0] d_start, d_fwd, d_ctr, a_start, a_fwd, a_ctr, half;
  logic signed [WE-1:0] probe_s, over_s, tol_s;
  logic [W-1:0] dsw, dfw, dcw, adv_cmd;
  logic adv_dir;
  logic [dhcc_pkg::TICKS_W-1:0] at_inc;
  logic [dhcc_pkg::SETTLE_W-1:0] sc_inc;

  function automatic logic [W-1:0] j_dn_clamp(input logic signed [WE-1:0] j,
                                              input logic signed [WE-1:0] l,
                                              input logic signed [WE-1:0] h);
    logic signed [WE-1:0] r;
    begin
      if (j < l) r = l;
      else if (j > h) r = h;
      else r = j;
      return r[W-1:0];
    end
  endfunction

  always_comb begin
    a_act = !sa;
    b_act = !sb;
    both = a_act && b_act;
    levels = {sb, sa};
    up_down = (cfg.mount_mode == dhcc_pkg::MODE_NORMAL);
    bot_act = up_down ? b_act : a_act;
    top_act = up_down ? a_act : b_act;
    lo = WE'(signed'(cfg.limit_min));
    hi = WE'(signed'(cfg.limit_max));
    cmd_s = WE'(signed'(command_reg));
    stp = WE'({1'b0, cfg.step_size});
    j_up = cmd_s + stp;
    j_dn = cmd_s - stp;
    probe_s = WE'({1'b0, cfg.probe_travel});
    over_s = WE'({1'b0, cfg.overtravel});
    tol_s = WE'({1'b0, cfg.final_tolerance});
    dsw = position - phase_start_angle;
    dfw = position - forward_edge_angle;
    dcw = center_target - position;
    d_start = WE'(signed'(dsw));
    d_fwd = WE'(signed'(dfw));
    d_ctr = WE'(signed'(dcw));
    a_start = d_start[WE-1] ? -d_start : d_start;
    a_fwd = d_fwd[WE-1] ? -d_fwd : d_fwd;
    a_ctr = d_ctr[WE-1] ? -d_ctr : d_ctr;
    half = d_fwd >>> 1;
    at_inc = approach_ticks + 1'b1;
    sc_inc = settle_count + 1'b1;

    // direction used by the shared stepper this tick
    case (phase_reg)
      dhcc_pkg::PH_PROBE: adv_dir = up_down;
      dhcc_pkg::PH_CENTER: adv_dir = !(a_ctr != 0 && !d_ctr[WE-1]);
      default: adv_dir = moving_down;
    endcase
    jsel = adv_dir ? j_dn : j_up;
    if (jsel < lo) clamped = lo;
    else if (jsel > hi) clamped = hi;
    else clamped = jsel;
    adv_cmd = clamped[W-1:0];

    status_next = status_reg;
    phase_next = phase_reg;
    md_next = moving_down;
    pba_next = prev_both_active;
    ra_next = reverse_armed;
    cmd_next = command_reg;
    psa_next = phase_start_angle;
    fea_next = forward_edge_angle;
    ct_next = center_target;
    sc_next = settle_count;
    at_next = approach_ticks;
    pl_next = prev_levels;
    tc_next = transition_count;
    strobe = 1'b0;

    if (!action) begin
      status_next = dhcc_pkg::ST_CAL;
      phase_next = dhcc_pkg::PH_PROBE;
      cmd_next = position;
      psa_next = position;
      md_next = up_down;
      pba_next = both;
      fea_next = '0;
      ct_next = '0;
      ra_next = 1'b0;
      sc_next = '0;
      at_next = '0;
      pl_next = levels;
      tc_next = '0;
    end else if (status_reg == dhcc_pkg::ST_CAL) begin
      pl_next = levels;
      if (cfg.mount_mode != dhcc_pkg::MODE_NORMAL && cfg.mount_mode != dhcc_pkg::MODE_MIRROR) begin
        status_next = dhcc_pkg::ST_FAIL;
        cmd_next = position;
      end else begin
        case (phase_reg)
          dhcc_pkg::PH_PROBE: begin
            if (both) begin
              md_next = !up_down;
              phase_next = dhcc_pkg::PH_BACK;
              psa_next = position;
            end else if (bot_act || top_act) begin
              md_next = bot_act ? up_down : !up_down;
              phase_next = dhcc_pkg::PH_EDGE;
              tc_next = '0;
              psa_next = position;
              pba_next = 1'b0;
            end else if (a_start >= probe_s) begin
              status_next = dhcc_pkg::ST_FAIL;
              cmd_next = position;
            end else begin
              cmd_next = adv_cmd;
            end
          end
          dhcc_pkg::PH_BACK: begin
            if (!both) begin
              md_next = up_down;
              phase_next = dhcc_pkg::PH_EDGE;
              tc_next = '0;
              psa_next = position;
              pba_next = 1'b0;
            end else if (a_start >= probe_s) begin
              status_next = dhcc_pkg::ST_FAIL;
              cmd_next = position;
            end else begin
              cmd_next = adv_cmd;
            end
          end
          dhcc_pkg::PH_EDGE: begin
            // bottom sensor transitions, saturating
            if ((up_down ? (levels[1] ^ prev_levels[1]) : (levels[0] ^ prev_levels[0]))
                && transition_count != 16'hFFFF)
              tc_next = transition_count + 1'b1;
            if (!prev_both_active && both) begin
              fea_next = position;
              pba_next = 1'b1;
              ra_next = 1'b0;
              phase_next = dhcc_pkg::PH_REV;
            end else begin
              pba_next = both;
              if (jsel > hi || jsel < lo) begin
                status_next = dhcc_pkg::ST_FAIL;
                cmd_next = position;
              end else begin
                cmd_next = adv_cmd;
              end
            end
          end
          dhcc_pkg::PH_REV: begin
            if (reverse_armed && !prev_both_active && both) begin
              ct_next = forward_edge_angle + half[W-1:0];
              phase_next = dhcc_pkg::PH_CENTER;
              sc_next = '0;
              at_next = '0;
            end else begin
              if (!reverse_armed && a_fwd >= over_s) begin
                md_next = !moving_down;
                ra_next = 1'b1;
              end
              pba_next = both;
              // reversal flips the stepping direction in the same tick
              if (!reverse_armed && a_fwd >= over_s)
                cmd_next = (!moving_down) ? j_dn_clamp(j_dn, lo, hi) : j_dn_clamp(j_up, lo, hi);
              else
                cmd_next = adv_cmd;
              if (a_fwd > probe_s) begin
                status_next = dhcc_pkg::ST_FAIL;
                cmd_next = position;
              end
            end
          end
          dhcc_pkg::PH_CENTER: begin
            at_next = at_inc;
            if (at_inc > {1'b0, cfg.timeout_ticks}) begin
              status_next = dhcc_pkg::ST_FAIL;
              cmd_next = position;
            end else begin
              cmd_next = (a_ctr > stp) ? adv_cmd : position;
              sc_next = (a_ctr <= tol_s && both) ? sc_inc : '0;
              if ((a_ctr <= tol_s && both) &&
                  sc_inc >= SW'(dhcc_pkg::SETTLE_TICKS)) begin
                cmd_next = position;
                status_next = dhcc_pkg::ST_OK;
                strobe = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status_reg <= dhcc_pkg::ST_IDLE;
      phase_reg <= dhcc_pkg::PH_PROBE;
      moving_down <= 1'b0;
      prev_both_active <= 1'b0;
      reverse_armed <= 1'b0;
      command_reg <= '0;
      phase_start_angle <= '0;
      forward_edge_angle <= '0;
      center_target <= '0;
      settle_count <= '0;
      approach_ticks <= '0;
      prev_levels <= 2'b11;
      transition_count <= '0;
      res_strobe <= 1'b0;
    end else if (en) begin
      status_reg <= status_next;
      phase_reg <= phase_next;
      moving_down <= md_next;
      prev_both_active <= pba_next;
      reverse_armed <= ra_next;
      command_reg <= cmd_next;
      phase_start_angle <= psa_next;
      forward_edge_angle <= fea_next;
      center_target <= ct_next;
      settle_count <= sc_next;
      approach_ticks <= at_next;
      prev_levels <= pl_next;
      transition_count <= tc_next;
      res_strobe <= strobe;
    end
  end

  assign res_command = command_reg;
  assign res_status = status_reg;
  assign res_phase = phase_reg;
  assign res_trans = transition_count;
endmodule

// ===== tb/tb_dual_hall_center_calibration.sv =====
// testbench for the dual hall center calibration sequencer: drives ticks, predicts results
`timescale 1ns / 100ps

module tb_dual_hall_center_calibration;
  localparam int LIMIT_CYCLES = 1500000;

  // scoreboard: homing predictor plus queue of expected result words
  class homing_scoreboard;
    logic [1:0] mode;
    logic [15:0] stp;
    logic [23:0] lmin, lmax;
    logic [22:0] probe, over, tol;
    logic [15:0] tmo;
    logic [1:0] status;
    logic [2:0] phase;
    bit down, prev_both, armed;
    logic [23:0] cmd, start_ang, fwd_ang, center;
    int unsigned settle, ticks;
    logic [1:0] prev_lv;
    int unsigned trans;
    logic [47:0] expected_words[$];
    int errors;
    int n_ok, n_fail;

    function void reset_all();
      mode = dhcc_pkg::MODE_NORMAL; stp = 67; lmin = 24'hE00000; lmax = 24'h200000;
      probe = 1398101; over = 699051; tol = 46603; tmo = 40000;
      status = dhcc_pkg::ST_IDLE; phase = dhcc_pkg::PH_PROBE;
      down = 0; prev_both = 0; armed = 0;
      cmd = 0; start_ang = 0; fwd_ang = 0; center = 0;
      settle = 0; ticks = 0; prev_lv = 2'b11; trans = 0;
      expected_words.delete(); errors = 0; n_ok = 0; n_fail = 0;
    endfunction

    function void write_reg(logic [dhcc_pkg::ADDR_W-1:0] addr, logic [31:0] v);
      case (addr)
        dhcc_pkg::REG_MODE: mode = v[1:0];
        dhcc_pkg::REG_STEP: stp = v[15:0];
        dhcc_pkg::REG_LMIN: lmin = v[23:0];
        dhcc_pkg::REG_LMAX: lmax = v[23:0];
        dhcc_pkg::REG_PROBE: probe = v[22:0];
        dhcc_pkg::REG_OVER: over = v[22:0];
        dhcc_pkg::REG_TOL: tol = v[22:0];
        dhcc_pkg::REG_TIMEOUT: tmo = v[15:0];
        default: ;
      endcase
    endfunction

    function longint sx(logic [23:0] v);
      return longint'($signed(v));
    endfunction

    function longint mag(longint x);
      return x < 0 ? -x : x;
    endfunction

    function longint clamp_joint(longint j);
      if (j < sx(lmin)) return sx(lmin);
      if (j > sx(lmax)) return sx(lmax);
      return j;
    endfunction

    function void step_cmd(bit dn);
      longint j;
      j = sx(cmd) + (dn ? -longint'(stp) : longint'(stp));
      cmd = 24'(clamp_joint(j));
    endfunction

    function void abort(logic [23:0] pos);
      status = dhcc_pkg::ST_FAIL; cmd = pos; n_fail++;
    endfunction

    function void note_input(bit act, logic [23:0] pos, bit la, bit lb);
      bit aa, ba, both, ud, bot, bact, tact, fin, strobe;
      logic [1:0] lv;
      longint trv, diff, half, err, aerr, j;
      aa = !la; ba = !lb; both = aa && ba; lv = {lb, la}; strobe = 0;
      if (!act) begin
        status = dhcc_pkg::ST_CAL; phase = dhcc_pkg::PH_PROBE; cmd = pos; start_ang = pos;
        down = (mode == dhcc_pkg::MODE_NORMAL); prev_both = both;
        fwd_ang = 0; center = 0; armed = 0; settle = 0; ticks = 0;
        prev_lv = lv; trans = 0;
      end else if (status == dhcc_pkg::ST_CAL) begin
        if (mode != dhcc_pkg::MODE_NORMAL && mode != dhcc_pkg::MODE_MIRROR) begin
          abort(pos);
        end else begin
          ud = (mode == dhcc_pkg::MODE_NORMAL);
          bot = ud;
          bact = bot ? ba : aa;
          tact = bot ? aa : ba;
          case (phase)
            dhcc_pkg::PH_PROBE: begin
              trv = mag(sx(pos - start_ang));
              if (both) begin
                down = !ud; phase = dhcc_pkg::PH_BACK; start_ang = pos;
              end else if (bact || tact) begin
                down = bact ? ud : !ud;
                phase = dhcc_pkg::PH_EDGE; trans = 0; start_ang = pos; prev_both = 0;
              end else if (trv >= longint'(probe)) abort(pos);
              else step_cmd(ud);
            end
            dhcc_pkg::PH_BACK: begin
              trv = mag(sx(pos - start_ang));
              if (!both) begin
                down = ud; phase = dhcc_pkg::PH_EDGE; trans = 0; start_ang = pos;
                prev_both = 0;
              end else if (trv >= longint'(probe)) abort(pos);
              else step_cmd(down);
            end
            dhcc_pkg::PH_EDGE: begin
              if (((lv ^ prev_lv) & (bot ? 2'b10 : 2'b01)) != 0 && trans < 65535)
                trans++;
              if (!prev_both && both) begin
                fwd_ang = pos; prev_both = 1; armed = 0; phase = dhcc_pkg::PH_REV;
              end else begin
                prev_both = both;
                j = sx(cmd) + (down ? -longint'(stp) : longint'(stp));
                if (j > sx(lmax) || j < sx(lmin)) abort(pos);
                else cmd = 24'(clamp_joint(j));
              end
            end
            dhcc_pkg::PH_REV: begin
              fin = 0;
              if (!armed) begin
                if (mag(sx(pos - fwd_ang)) >= longint'(over)) begin
                  down = !down; armed = 1;
                end
              end else if (!prev_both && both) begin
                diff = sx(pos - fwd_ang);
                half = diff >>> 1;
                center = 24'(sx(fwd_ang) + half);
                phase = dhcc_pkg::PH_CENTER; settle = 0; ticks = 0; fin = 1;
              end
              if (!fin) begin
                prev_both = both;
                step_cmd(down);
                if (mag(sx(pos - fwd_ang)) > longint'(probe)) abort(pos);
              end
            end
            dhcc_pkg::PH_CENTER: begin
              err = sx(center - pos);
              aerr = mag(err);
              if (aerr > longint'(stp)) step_cmd(err <= 0);
              else cmd = pos;
              ticks++;
              if (ticks > tmo) abort(pos);
              else begin
                if (aerr <= longint'(tol) && both) settle++;
                else settle = 0;
                if (settle >= dhcc_pkg::SETTLE_TICKS) begin
                  cmd = pos; status = dhcc_pkg::ST_OK; strobe = 1; n_ok++;
                end
              end
            end
            default: ;
          endcase
        end
        prev_lv = lv;
      end
      expected_words.push_back({16'(trans), strobe, phase, status, cmd});
    endfunction

    function void check_result(logic [47:0] got);
      logic [47:0] e;
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected: %h", got);
        errors++;
        return;
      end
      e = expected_words.pop_front();
      if (got[23:0] !== e[23:0]) begin
        $error("position_command exp %h got %h", e[23:0], got[23:0]); errors++;
      end
      if (got[25:24] !== e[25:24]) begin
        $error("cal_status exp %0d got %0d", e[25:24], got[25:24]); errors++;
      end
      if (got[28:26] !== e[28:26]) begin
        $error("cal_phase exp %0d got %0d", e[28:26], got[28:26]); errors++;
      end
      if (got[29] !== e[29]) begin
        $error("zero_strobe exp %0d got %0d", e[29], got[29]); errors++;
      end
      if (got[45:30] !== e[45:30]) begin
        $error("edge_transitions exp %0d got %0d", e[45:30], got[45:30]); errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic s_tvalid = 0, s_tready, s_tuser = 0;
  logic [31:0] s_tdata = 0;
  logic m_tvalid, m_tready = 0;
  logic [47:0] m_tdata;
  logic psel = 0, penable = 0, pwrite = 0, pready;
  logic [dhcc_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = 0, prdata;

  homing_scoreboard sb = new();
  int send_idle_pct = 0, recv_idle_pct = 0;
  int unsigned cycles = 0, n_items = 0, item_goal = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  dual_hall_center_calibration u_top (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAIL dual_hall_center_calibration");
      $finish;
    end
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  // receiver stall pattern
  always @(negedge clk) m_tready <= ($urandom_range(99) >= recv_idle_pct);

  task automatic cfg_write(logic [dhcc_pkg::ADDR_W-1:0] addr, logic [31:0] v);
    @(negedge clk);
    s_tvalid <= 1'b0;
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= v;
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    sb.write_reg(addr, v);
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // valid stays up after acceptance until the next falling edge, so words can follow
  // back to back; every caller that goes on reaches a falling edge first
  task automatic send_word(bit act, logic [23:0] pos, bit la, bit lb);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1; s_tuser <= act; s_tdata <= {6'b0, lb, la, pos};
    do @(posedge clk); while (!s_tready);
    sb.note_input(act, pos, la, lb);
    n_items++;
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // simulated joint: a magnet zone [zlo,zhi) per sensor, position follows command
  task automatic homing_run(int unsigned n_ticks);
    logic [23:0] pos, a_lo, b_lo;
    int unsigned wa, wb, k;
    bit la, lb;
    pos = 24'($urandom_range(4000) - 2000);
    a_lo = 24'($urandom_range(3000) - 1500);
    wa = $urandom_range(2500, 200);
    b_lo = a_lo + 24'($urandom_range(wa - 1));
    wb = $urandom_range(2500, 200);
    send_word(1'b0, pos, 1'b1, 1'b1);
    for (k = 0; k < n_ticks; k++) begin
      if ($urandom_range(9) == 0) pos = 24'($urandom);
      else pos = sb.cmd + 24'($urandom_range(6) - 3);
      la = !(24'(pos - a_lo) < wa);
      lb = !(24'(pos - b_lo) < wb);
      if ($urandom_range(40) == 0) la = !la;
      send_word(1'b1, pos, la, lb);
      if (sb.status != dhcc_pkg::ST_CAL && $urandom_range(3) == 0) break;
      if (n_items >= item_goal) break;
    end
  endtask

  task automatic set_homing_cfg(bit mirror);
    cfg_write(dhcc_pkg::REG_MODE,
              mirror ? 32'(dhcc_pkg::MODE_MIRROR) : 32'(dhcc_pkg::MODE_NORMAL));
    cfg_write(dhcc_pkg::REG_STEP, $urandom_range(120, 5));
    cfg_write(dhcc_pkg::REG_LMIN, 32'(-20000));
    cfg_write(dhcc_pkg::REG_LMAX, 20000);
    cfg_write(dhcc_pkg::REG_PROBE, $urandom_range(30000, 6000));
    cfg_write(dhcc_pkg::REG_OVER, $urandom_range(1500, 100));
    cfg_write(dhcc_pkg::REG_TOL, $urandom_range(300, 40));
    cfg_write(dhcc_pkg::REG_TIMEOUT, $urandom_range(400, 60));
  endtask

  initial begin
    int ph, run;
    sb.reset_all();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed: extremes, idle ticks, single and reserved mount, inverted limits, zero and full-scale settings
    send_word(1'b1, 24'hFFFFFF, 1'b0, 1'b0);
    send_word(1'b0, 24'h000000, 1'b1, 1'b1);
    send_word(1'b1, 24'h800000, 1'b1, 1'b1);
    send_word(1'b1, 24'h7FFFFF, 1'b0, 1'b1);
    send_word(1'b1, 24'h7FFFFF, 1'b1, 1'b0);
    send_word(1'b1, 24'h7FFFFF, 1'b0, 1'b0);
    drain();
    cfg_write(dhcc_pkg::REG_MODE, 32'(dhcc_pkg::MODE_SINGLE));
    send_word(1'b0, 24'h123456, 1'b0, 1'b0);
    send_word(1'b1, 24'h123456, 1'b0, 1'b0);
    drain();
    cfg_write(dhcc_pkg::REG_MODE, 32'(dhcc_pkg::MODE_RSVD));
    send_word(1'b0, 24'hABCDEF, 1'b1, 1'b0);
    send_word(1'b1, 24'hABCDEF, 1'b1, 1'b0);
    drain();
    cfg_write(dhcc_pkg::REG_MODE, 32'(dhcc_pkg::MODE_MIRROR));
    cfg_write(dhcc_pkg::REG_STEP, 65535);
    cfg_write(dhcc_pkg::REG_LMIN, 32'h007FFFFF);
    cfg_write(dhcc_pkg::REG_LMAX, 32'h00800000);
    send_word(1'b0, 24'h000010, 1'b1, 1'b1);
    send_word(1'b1, 24'h000010, 1'b1, 1'b1);
    drain();
    cfg_write(dhcc_pkg::REG_STEP, 0);
    cfg_write(dhcc_pkg::REG_PROBE, 0);
    cfg_write(dhcc_pkg::REG_OVER, 32'h007FFFFF);
    cfg_write(dhcc_pkg::REG_TOL, 32'h007FFFFF);
    cfg_write(dhcc_pkg::REG_TIMEOUT, 0);
    send_word(1'b0, 24'h000000, 1'b1, 1'b1);
    send_word(1'b1, 24'h400000, 1'b1, 1'b1);
    drain();
    cfg_write(dhcc_pkg::REG_TIMEOUT, 65535);
    cfg_write(dhcc_pkg::REG_PROBE, 32'h007FFFFF);
    cfg_write(dhcc_pkg::REG_OVER, 0);
    cfg_write(dhcc_pkg::REG_TOL, 0);
    drain();
    // random phases with changing idle mixes
    run = 0;
    for (ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 33 : (ph == 1) ? 50 : 0;
      recv_idle_pct = (ph == 0) ? 50 : (ph == 1) ? 33 : 0;
      item_goal = unsigned'(550 * (ph + 1));
      while (n_items < item_goal) begin
        drain();
        set_homing_cfg(run[0]);
        homing_run(240);
        if ($urandom_range(4) == 0) begin
          repeat (4) send_word(1'($urandom_range(1)), 24'($urandom),
                               1'($urandom_range(1)), 1'($urandom_range(1)));
        end
        run++;
      end
      drain();
    end
    drain();
    $display("covered %0d words: %0d centered homings, %0d failures, all mount modes",
             n_items, sb.n_ok, sb.n_fail);
    if (sb.errors == 0 && sb.expected_words.size() == 0) begin
      $display("PASS dual_hall_center_calibration");
    end else begin
      $display("FAIL dual_hall_center_calibration");
    end
    $finish;
  end
endmodule
